>>> rtl/gld_pkg.sv
// Shared constants, types and helpers for the GIF LZW decoder core.
// No dependencies; every other file of the block imports this package.
package gld_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int TABLE_DEPTH   = 1 << MAX_CODE_BITS;
    localparam int BUFFER_BITS   = 32;
    localparam int HELD_W        = $clog2(BUFFER_BITS + 1);
    localparam int WIDTH_W       = 4;
    localparam int NEXT_W        = MAX_CODE_BITS + 1;
    localparam int DICT_W        = MAX_CODE_BITS + 16;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_PUSH  = 2'd1;
    localparam logic [1:0] OP_PULL  = 2'd2;

    localparam logic [2:0] ST_PIXEL   = 3'd0;
    localparam logic [2:0] ST_NEED    = 3'd1;
    localparam logic [2:0] ST_ENDED   = 3'd2;
    localparam logic [2:0] ST_CLEAR   = 3'd3;
    localparam logic [2:0] ST_TAKEN   = 3'd4;
    localparam logic [2:0] ST_REFUSED = 3'd5;
    localparam logic [2:0] ST_BAD     = 3'd6;

    localparam logic [3:0] MIN_CODE_RESET = 4'd8;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_PUSH  = 2'd1,
        KIND_PULL  = 2'd2,
        KIND_NOP   = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data_byte;
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE      = 4'b0001,
        S_POP       = 4'b0010,
        S_WALK      = 4'b0100,
        S_WALK_DATA = 4'b1000
    } back_state_t;

    function automatic logic [3:0] root_bits(input logic [3:0] mcs);
        logic [3:0] r;
        begin
            r = mcs;
            if (mcs < 4'd2)
                r = 4'd2;
            else if (mcs > 4'd8)
                r = 4'd8;
            return r;
        end
    endfunction

endpackage

>>> rtl/gld_if.sv
// Channel interfaces of the GIF LZW decoder core: command, result, config.
// Depends on gld_pkg.
interface gld_cmd_if;
    import gld_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface gld_res_if;
    import gld_pkg::*;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] pixel_index;
    modport source (output valid, output status, output pixel_index, input ready);
    modport sink (input valid, input status, input pixel_index, output ready);
endinterface

interface gld_cfg_if;
    import gld_pkg::*;
    logic       valid;
    logic       ready;
    logic [3:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/gld_front.sv
// Front end: classifies incoming commands and queues them in two entries.
// Depends on gld_pkg.
module gld_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    in_opcode,
    input  logic [7:0]    in_byte,
    output logic          q_valid,
    output gld_pkg::cmd_t q_entry,
    input  logic          q_pop
);
    import gld_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       classified;
    logic       push;

    always_comb
    begin
        classified.data_byte = in_byte;
        case (in_opcode)
            OP_START: classified.kind = KIND_START;
            OP_PUSH:  classified.kind = KIND_PUSH;
            OP_PULL:  classified.kind = KIND_PULL;
            default:  classified.kind = KIND_NOP;
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_entry  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= classified;
    end

endmodule

>>> rtl/gld_back.sv
// Back end: bit buffer, LZW dictionary, symbol stack and result register.
// Depends on gld_pkg; takes commands from gld_front.
module gld_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [3:0]    min_code_size,
    input  logic          q_valid,
    input  gld_pkg::cmd_t q_entry,
    output logic          q_pop,
    input  logic          out_ready,
    output logic          out_valid,
    output logic [2:0]    out_status,
    output logic [7:0]    out_pixel
);
    import gld_pkg::*;

    logic [DICT_W-1:0] dict_mem  [TABLE_DEPTH];
    logic [7:0]        stack_mem [TABLE_DEPTH];

    back_state_t             state_reg, state_next;
    logic [BUFFER_BITS-1:0]  buf_reg, buf_next;
    logic [HELD_W-1:0]       held_reg, held_next;
    logic [WIDTH_W-1:0]      width_reg, width_next;
    logic [NEXT_W-1:0]       next_code_reg, next_code_next;
    logic [MAX_CODE_BITS-1:0] prev_reg, prev_next;
    logic [7:0]              prev_first_reg, prev_first_next;
    logic                    have_prev_reg, have_prev_next;
    logic [NEXT_W-1:0]       count_reg, count_next;
    logic                    ended_reg, ended_next;
    logic [MAX_CODE_BITS-1:0] code_reg, code_next;
    logic [MAX_CODE_BITS-1:0] walk_reg, walk_next;
    logic                    kw_reg, kw_next;
    logic                    out_valid_reg;
    logic [2:0]              status_reg, status_next;
    logic [7:0]              pixel_reg, pixel_next;
    logic                    deliver;

    logic                     dict_we;
    logic [MAX_CODE_BITS-1:0] dict_waddr, dict_raddr;
    logic [DICT_W-1:0]        dict_wdata, dict_rdata_reg;
    logic                     stack_we;
    logic [MAX_CODE_BITS-1:0] stack_waddr, stack_raddr;
    logic [7:0]               stack_wdata, stack_rdata_reg;

    logic [3:0]               root_w;
    logic [8:0]               clear_code;
    logic [8:0]               first_dict;
    logic [MAX_CODE_BITS-1:0] code;
    logic [BUFFER_BITS-1:0]   code_mask;
    logic [NEXT_W-1:0]        width_limit;
    logic [NEXT_W-1:0]        grown_next;
    logic [7:0]               root_sym;
    logic                     out_free;
    logic                     walk_dict;

    assign root_w      = root_bits(min_code_size);
    assign clear_code  = 9'd1 << root_w;
    assign first_dict  = clear_code + 9'd2;
    assign code_mask   = (BUFFER_BITS'(1) << width_reg) - BUFFER_BITS'(1);
    assign code        = MAX_CODE_BITS'(buf_reg & code_mask);
    assign width_limit = NEXT_W'(1) << width_reg;
    assign out_free    = !out_valid_reg || out_ready;
    assign walk_dict   = (walk_reg >= MAX_CODE_BITS'(first_dict));
    assign root_sym    = walk_reg[7:0];
    assign grown_next  = (kw_reg || next_code_reg < NEXT_W'(TABLE_DEPTH)) ?
                         next_code_reg + NEXT_W'(1) : next_code_reg;

    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_pixel  = pixel_reg;

    always_comb
    begin
        state_next      = state_reg;
        buf_next        = buf_reg;
        held_next       = held_reg;
        width_next      = width_reg;
        next_code_next  = next_code_reg;
        prev_next       = prev_reg;
        prev_first_next = prev_first_reg;
        have_prev_next  = have_prev_reg;
        count_next      = count_reg;
        ended_next      = ended_reg;
        code_next       = code_reg;
        walk_next       = walk_reg;
        kw_next         = kw_reg;
        status_next     = status_reg;
        pixel_next      = pixel_reg;
        deliver         = 1'b0;
        q_pop           = 1'b0;
        dict_we         = 1'b0;
        dict_waddr      = next_code_reg[MAX_CODE_BITS-1:0];
        dict_wdata      = {prev_reg, root_sym, kw_reg ? root_sym : prev_first_reg};
        dict_raddr      = walk_reg;
        stack_we        = 1'b0;
        stack_waddr     = count_reg[MAX_CODE_BITS-1:0];
        stack_wdata     = dict_rdata_reg[15:8];
        stack_raddr     = MAX_CODE_BITS'(count_reg - NEXT_W'(1));

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop       = 1'b1;
                    pixel_next  = 8'd0;
                    case (q_entry.kind)
                        KIND_START:
                        begin
                            width_next     = root_w + 4'd1;
                            next_code_next = NEXT_W'(first_dict);
                            have_prev_next = 1'b0;
                            buf_next       = '0;
                            held_next      = '0;
                            prev_next      = '0;
                            count_next     = '0;
                            ended_next     = 1'b0;
                            status_next    = ST_CLEAR;
                            deliver        = 1'b1;
                        end
                        KIND_PUSH:
                        begin
                            deliver     = 1'b1;
                            status_next = ST_REFUSED;
                            if (held_reg <= HELD_W'(BUFFER_BITS - 8))
                            begin
                                buf_next    = buf_reg |
                                    (BUFFER_BITS'(q_entry.data_byte) << held_reg);
                                held_next   = held_reg + HELD_W'(8);
                                status_next = ST_TAKEN;
                            end
                        end
                        KIND_PULL:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - NEXT_W'(1);
                                state_next = S_POP;
                            end
                            else if (ended_reg)
                            begin
                                status_next = ST_ENDED;
                                deliver     = 1'b1;
                            end
                            else if (held_reg < HELD_W'(width_reg))
                            begin
                                status_next = ST_NEED;
                                deliver     = 1'b1;
                            end
                            else
                            begin
                                buf_next  = buf_reg >> width_reg;
                                held_next = held_reg - HELD_W'(width_reg);
                                code_next = code;
                                if (code == MAX_CODE_BITS'(clear_code))
                                begin
                                    width_next     = root_w + 4'd1;
                                    next_code_next = NEXT_W'(first_dict);
                                    have_prev_next = 1'b0;
                                    status_next    = ST_CLEAR;
                                    deliver        = 1'b1;
                                end
                                else if (code == MAX_CODE_BITS'(clear_code + 9'd1))
                                begin
                                    ended_next  = 1'b1;
                                    status_next = ST_ENDED;
                                    deliver     = 1'b1;
                                end
                                else if (!have_prev_reg)
                                begin
                                    deliver = 1'b1;
                                    if (code >= MAX_CODE_BITS'(clear_code))
                                        status_next = ST_BAD;
                                    else
                                    begin
                                        prev_next       = code;
                                        prev_first_next = code[7:0];
                                        have_prev_next  = 1'b1;
                                        if (next_code_reg == width_limit &&
                                            width_reg < WIDTH_W'(MAX_CODE_BITS))
                                            width_next = width_reg + 4'd1;
                                        status_next = ST_PIXEL;
                                        pixel_next  = code[7:0];
                                    end
                                end
                                else if (NEXT_W'(code) < next_code_reg)
                                begin
                                    walk_next  = code;
                                    kw_next    = 1'b0;
                                    state_next = S_WALK;
                                end
                                else if (NEXT_W'(code) == next_code_reg &&
                                         next_code_reg < NEXT_W'(TABLE_DEPTH))
                                begin
                                    stack_we    = 1'b1;
                                    stack_wdata = prev_first_reg;
                                    count_next  = count_reg + NEXT_W'(1);
                                    walk_next   = prev_reg;
                                    kw_next     = 1'b1;
                                    state_next  = S_WALK;
                                end
                                else
                                begin
                                    status_next = ST_BAD;
                                    deliver     = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = ST_REFUSED;
                            deliver     = 1'b1;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                status_next = ST_PIXEL;
                pixel_next  = stack_rdata_reg;
                deliver     = 1'b1;
                state_next  = S_IDLE;
            end
            S_WALK:
            begin
                if (walk_dict)
                    state_next = S_WALK_DATA;
                else
                begin
                    dict_we         = kw_reg || next_code_reg < NEXT_W'(TABLE_DEPTH);
                    next_code_next  = grown_next;
                    if (grown_next == width_limit && width_reg < WIDTH_W'(MAX_CODE_BITS))
                        width_next = width_reg + 4'd1;
                    prev_next       = code_reg;
                    prev_first_next = root_sym;
                    have_prev_next  = 1'b1;
                    status_next     = ST_PIXEL;
                    pixel_next      = root_sym;
                    deliver         = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_WALK_DATA:
            begin
                stack_we   = 1'b1;
                count_next = count_reg + NEXT_W'(1);
                walk_next  = dict_rdata_reg[DICT_W-1:16];
                state_next = S_WALK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            buf_reg        <= '0;
            held_reg       <= '0;
            width_reg      <= root_bits(MIN_CODE_RESET) + 4'd1;
            next_code_reg  <= NEXT_W'((9'd1 << root_bits(MIN_CODE_RESET)) + 9'd2);
            prev_reg       <= '0;
            prev_first_reg <= '0;
            have_prev_reg  <= 1'b0;
            count_reg      <= '0;
            ended_reg      <= 1'b0;
            kw_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            buf_reg        <= buf_next;
            held_reg       <= held_next;
            width_reg      <= width_next;
            next_code_reg  <= next_code_next;
            prev_reg       <= prev_next;
            prev_first_reg <= prev_first_next;
            have_prev_reg  <= have_prev_next;
            count_reg      <= count_next;
            ended_reg      <= ended_next;
            kw_reg         <= kw_next;
            if (deliver)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg   <= code_next;
        walk_reg   <= walk_next;
        status_reg <= status_next;
        pixel_reg  <= pixel_next;
    end

    always_ff @(posedge clk)
    begin
        if (dict_we)
            dict_mem[dict_waddr] <= dict_wdata;
        dict_rdata_reg <= dict_mem[dict_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
            stack_mem[stack_waddr] <= stack_wdata;
        stack_rdata_reg <= stack_mem[stack_raddr];
    end

endmodule

>>> rtl/gif_lzw_decoder_core.sv
// Top level of the GIF LZW decoder: config register, front queue, back end.
// Depends on gld_pkg, gld_if, gld_front and gld_back.
//
//  channel | dir | transfer moves
//  cmd     | in  | opcode, data_byte
//  result  | out | status, pixel_index
//  cfg     | in  | data (min_code_size)
//
// A command is registered in the queue before the back end sees it. The back end
// answers start, push, status-only pulls and root codes with no previous code
// from S_IDLE, a pull served from the stack through S_POP, and a pull that expands
// a code through S_WALK and S_WALK_DATA, one dictionary read per link walked.
// Reset is asynchronous; memories are not cleared. The two-entry queue and the
// result register let the front accept and the back finish while the sink stalls.
module gif_lzw_decoder_core (
    input  logic       clk,
    input  logic       rst_n,
    gld_cmd_if.sink    cmd,
    gld_res_if.source  result,
    gld_cfg_if.sink    cfg
);
    import gld_pkg::*;

    logic [3:0] min_code_size_reg;
    logic       q_valid;
    logic       q_pop;
    cmd_t       q_entry;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_code_size_reg <= MIN_CODE_RESET;
        else if (cfg.valid)
            min_code_size_reg <= cfg.data;
    end

    gld_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .in_opcode (cmd.opcode),
        .in_byte   (cmd.data_byte),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop)
    );

    gld_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .min_code_size (min_code_size_reg),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop),
        .out_ready     (result.ready),
        .out_valid     (result.valid),
        .out_status    (result.status),
        .out_pixel     (result.pixel_index)
    );

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.status <= ST_BAD)
        else $error("result status out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status != ST_PIXEL |-> result.pixel_index == 8'd0)
        else $error("pixel index set on a non-pixel result");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("back end popped an empty queue");
`endif

endmodule

>>> test/tb_gif_lzw_decoder_core.sv
// Self-checking testbench for gif_lzw_decoder_core: LZW code streams, noise and
// config changes drive the block; a scoreboard class predicts each result.
// Depends on gld_pkg and the channel interfaces in gld_if.
`timescale 1ns / 1ps

import gld_pkg::*;

typedef struct {
    logic [2:0] status;
    logic [7:0] pixel;
} lzw_result_t;

class lzw_decode_model;
    int unsigned min_size;
    int unsigned held;
    int unsigned width;
    int unsigned next_free;
    int unsigned prev_code;
    int unsigned stack_cnt;
    bit          have_prev;
    bit          ended;
    logic [63:0] bitbuf;
    logic [11:0] prefix_mem [TABLE_DEPTH];
    logic [7:0]  suffix_mem [TABLE_DEPTH];
    logic [7:0]  lead_mem [TABLE_DEPTH];
    logic [7:0]  sym_stack [TABLE_DEPTH];
    lzw_result_t pending_results [$];
    int          errors;

    function new();
        min_size = MIN_CODE_RESET;
        errors = 0;
        start_frame();
    endfunction

    function int unsigned roots();
        if (min_size < 2)
            return 2;
        if (min_size > 8)
            return 8;
        return min_size;
    endfunction

    function void clear_dict();
        width = roots() + 1;
        next_free = (1 << roots()) + 2;
        have_prev = 0;
    endfunction

    function void start_frame();
        clear_dict();
        bitbuf = '0;
        held = 0;
        prev_code = 0;
        stack_cnt = 0;
        ended = 0;
    endfunction

    function void push_sym(int unsigned s);
        if (stack_cnt < TABLE_DEPTH)
        begin
            sym_stack[stack_cnt] = s[7:0];
            stack_cnt++;
        end
    endfunction

    function void expand(int unsigned c, int unsigned fd);
        int unsigned guard;
        guard = 0;
        c = c % TABLE_DEPTH;
        while (c >= fd && guard < TABLE_DEPTH)
        begin
            push_sym(suffix_mem[c]);
            c = prefix_mem[c];
            guard++;
        end
        push_sym(c);
    endfunction

    function int unsigned lead_of(int unsigned c, int unsigned fd);
        c = c % TABLE_DEPTH;
        return (c >= fd) ? lead_mem[c] : (c & 8'hFF);
    endfunction

    function void add_entry(int unsigned suffix, int unsigned lead);
        prefix_mem[next_free] = prev_code[11:0];
        suffix_mem[next_free] = suffix[7:0];
        lead_mem[next_free] = lead[7:0];
        next_free++;
    endfunction

    function logic [2:0] pull(output logic [7:0] pix);
        int unsigned clr;
        int unsigned fd;
        int unsigned code;
        int unsigned f;
        pix = 0;
        if (stack_cnt > 0)
        begin
            stack_cnt--;
            pix = sym_stack[stack_cnt];
            return ST_PIXEL;
        end
        if (ended)
            return ST_ENDED;
        if (held < width)
            return ST_NEED;
        code = 32'(bitbuf & ((64'd1 << width) - 64'd1));
        bitbuf = bitbuf >> width;
        held -= width;
        clr = 1 << roots();
        fd = clr + 2;
        if (code == clr)
        begin
            clear_dict();
            return ST_CLEAR;
        end
        if (code == clr + 1)
        begin
            ended = 1;
            return ST_ENDED;
        end
        if (!have_prev)
        begin
            if (code >= clr)
                return ST_BAD;
            push_sym(code);
        end
        else if (code < next_free)
        begin
            f = lead_of(code, fd);
            expand(code, fd);
            if (next_free < TABLE_DEPTH)
                add_entry(f, lead_of(prev_code, fd));
        end
        else if (code == next_free && next_free < TABLE_DEPTH)
        begin
            f = lead_of(prev_code, fd);
            push_sym(f);
            expand(prev_code, fd);
            add_entry(f, f);
        end
        else
            return ST_BAD;
        if (next_free == (1 << width) && width < MAX_CODE_BITS)
            width++;
        prev_code = code % TABLE_DEPTH;
        have_prev = 1;
        stack_cnt--;
        pix = sym_stack[stack_cnt];
        return ST_PIXEL;
    endfunction

    function void note_command(logic [1:0] op, logic [7:0] b);
        lzw_result_t r;
        logic [7:0] pix;
        r.status = ST_REFUSED;
        r.pixel = 0;
        if (op == OP_START)
        begin
            start_frame();
            r.status = ST_CLEAR;
        end
        else if (op == OP_PUSH)
        begin
            if (held + 8 <= BUFFER_BITS)
            begin
                bitbuf = bitbuf | (64'(b) << held);
                held += 8;
                r.status = ST_TAKEN;
            end
        end
        else if (op == OP_PULL)
        begin
            r.status = pull(pix);
            if (r.status == ST_PIXEL)
                r.pixel = pix;
        end
        pending_results = {pending_results, r};
    endfunction

    function void check_result(logic [2:0] st, logic [7:0] px);
        lzw_result_t e;
        if (pending_results.size() == 0)
        begin
            $error("unexpected result: status %0d pixel_index %0d", st, px);
            errors++;
            return;
        end
        e = pending_results.pop_front();
        if (st !== e.status)
        begin
            $error("status: expected %0d, actual %0d", e.status, st);
            errors++;
        end
        if (px !== e.pixel)
        begin
            $error("pixel_index: expected %0d, actual %0d", e.pixel, px);
            errors++;
        end
    endfunction
endclass

module tb_gif_lzw_decoder_core;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;

    logic clk;
    logic rst_n;
    int   cycle = 0;
    int   stall_left = 0;
    int   items_sent;
    bit   hold_go = 1'b0;
    bit   hold_done = 1'b0;

    gld_cmd_if cmd_ch ();
    gld_res_if res_ch ();
    gld_cfg_if cfg_ch ();

    lzw_decode_model model = new();

    int unsigned gen_width;
    int unsigned gen_next;
    int unsigned gen_clear;
    bit          gen_prev;
    logic [63:0] gen_acc;
    int unsigned gen_bits;
    logic [7:0]  stream_q [$];

    gif_lzw_decoder_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit calm();
        return (cycle / 600) % 4 == 0;
    endfunction

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (hold_go && !hold_done)
        begin
            res_ch.ready <= 1'b0;
            hold_done <= 1'b1;
            stall_left <= HOLD_CYCLES;
        end
        else if (stall_left > 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!calm() && $urandom_range(0, 7) == 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
        end
        else
            res_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            model.check_result(res_ch.status, res_ch.pixel_index);
    end

    task automatic send(logic [1:0] op, logic [7:0] b);
        int gap;
        if (!calm() && $urandom_range(0, 3) == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.opcode <= op;
        cmd_ch.data_byte <= b;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        model.note_command(op, b);
        items_sent++;
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (model.pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_config(logic [3:0] v);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        model.min_size = v;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic gen_begin();
        gen_clear = 1 << model.roots();
        gen_width = model.roots() + 1;
        gen_next = gen_clear + 2;
        gen_prev = 0;
        gen_acc = '0;
        gen_bits = 0;
        stream_q.delete();
    endtask

    task automatic emit(int unsigned code);
        bit ok;
        gen_acc = gen_acc | (64'(code) << gen_bits);
        gen_bits += gen_width;
        while (gen_bits >= 8)
        begin
            stream_q = {stream_q, gen_acc[7:0]};
            gen_acc = gen_acc >> 8;
            gen_bits -= 8;
        end
        ok = 1;
        if (code == gen_clear)
        begin
            gen_width = model.roots() + 1;
            gen_next = gen_clear + 2;
            gen_prev = 0;
            ok = 0;
        end
        else if (code == gen_clear + 1)
            ok = 0;
        else if (!gen_prev)
            ok = code < gen_clear;
        else if (code < gen_next || (code == gen_next && gen_next < TABLE_DEPTH))
        begin
            if (gen_next < TABLE_DEPTH)
                gen_next++;
        end
        else
            ok = 0;
        if (ok)
        begin
            if (gen_next == (1 << gen_width) && gen_width < MAX_CODE_BITS)
                gen_width++;
            gen_prev = 1;
        end
    endtask

    task automatic flush_stream();
        if (gen_bits > 0)
            stream_q = {stream_q, gen_acc[7:0]};
        gen_bits = 0;
    endtask

    task automatic emit_random(int root_pct);
        int unsigned hi;
        int unsigned c;
        int r;
        r = $urandom_range(0, 99);
        if (root_pct < 100 && r < 2)
            emit(gen_clear);
        else if (root_pct < 100 && r < 4)
            emit($urandom_range(0, (1 << gen_width) - 1));
        else if (!gen_prev || $urandom_range(0, 99) < root_pct)
            emit($urandom_range(0, gen_clear - 1));
        else
        begin
            hi = (gen_next < TABLE_DEPTH) ? gen_next : TABLE_DEPTH - 1;
            c = $urandom_range(0, hi);
            if (c == gen_clear || c == gen_clear + 1)
                c = $urandom_range(0, gen_clear - 1);
            emit(c);
        end
    endtask

    task automatic run_stream(int noise_pct);
        int guard;
        bit starving;
        bit can_push;
        logic [1:0] op;
        guard = 0;
        while (guard < 50000)
        begin
            guard++;
            if (model.ended)
                stream_q.delete();
            starving = model.stack_cnt == 0 && !model.ended && model.held < model.width;
            if (stream_q.size() == 0 && (model.ended || starving))
                break;
            can_push = stream_q.size() > 0 && model.held + 8 <= BUFFER_BITS;
            if ($urandom_range(0, 99) < noise_pct)
            begin
                case ($urandom_range(0, 2))
                    0: op = OP_PUSH;
                    1: op = OP_PULL;
                    default: op = KIND_NOP;
                endcase
                send(op, 8'($urandom_range(0, 255)));
            end
            else if (can_push && (starving || $urandom_range(0, 3) == 0))
                send(OP_PUSH, stream_q.pop_front());
            else
                send(OP_PULL, 8'($urandom_range(0, 255)));
        end
        repeat (2) send(OP_PULL, 8'h00);
    endtask

    initial
    begin
        logic [3:0] sizes [9];
        int n;
        int k;
        sizes = '{4'd2, 4'd8, 4'd5, 4'd0, 4'd3, 4'd15, 4'd7, 4'd4, 4'd6};
        items_sent = 0;
        rst_n <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.opcode <= OP_START;
        cmd_ch.data_byte <= 8'h00;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= MIN_CODE_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(OP_PULL, 8'h00);
        send(KIND_NOP, 8'hFF);
        send(OP_START, 8'hFF);
        gen_begin();
        emit(256);
        emit(300);
        emit(8'h41);
        emit(8'h41);
        emit(258);
        emit(300);
        emit(0);
        emit(255);
        emit(257);
        flush_stream();
        run_stream(0);
        send(OP_START, 8'h00);
        send(OP_PUSH, 8'h00);
        send(OP_PUSH, 8'hFF);
        send(OP_PUSH, 8'hAA);
        send(OP_PUSH, 8'h55);
        send(OP_PUSH, 8'h0F);
        repeat (4) send(OP_PULL, 8'h00);

        hold_go = 1'b1;
        repeat (12) send(OP_PULL, 8'h00);

        k = 0;
        while (items_sent < 400)
        begin
            write_config(sizes[k % 9]);
            k++;
            send(OP_START, 8'($urandom_range(0, 255)));
            gen_begin();
            n = $urandom_range(5, 60);
            repeat (n) emit_random(50);
            if ($urandom_range(0, 3) != 0)
                emit(gen_clear + 1);
            flush_stream();
            run_stream(3);
        end

        write_config(4'd2);
        send(OP_START, 8'h00);
        gen_begin();
        repeat (100) emit_random(90);
        emit(gen_clear + 1);
        flush_stream();
        run_stream(0);

        wait_drained();
        repeat (30) @(posedge clk);
        if (model.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
